// ===== rtl/rrd_pkg.sv =====
// shared types, constants and register codes of the ripple detector
package rrd_pkg;

	localparam int RIP_W      = 42;
	localparam int MOT_W      = 43;
	localparam int WLEN_W     = 12;
	localparam int CFG_CNT_W  = 32;
	localparam int MODE_W     = 2;
	localparam int CFG_DATA_W = 43;
	localparam int CFG_IDX_W  = 3;

	localparam int DEF_MAX_WINDOW  = 2048;
	localparam int DEF_SAMPLE_BITS = 16;
	localparam int DEF_COUNT_BITS  = 32;

	localparam int QUEUE_DEPTH = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RIP_THR    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MOT_THR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WLEN       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_ABOVE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REFR       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_MOTION = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEADY = 3'd7;

	// motion source codes, anything else means gate off
	localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EMG   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ACCEL = 2'd2;

	// register reset values
	localparam logic [WLEN_W-1:0]    RST_WLEN       = 12'd128;
	localparam logic [CFG_CNT_W-1:0] RST_MIN_ABOVE  = 32'd300;
	localparam logic [CFG_CNT_W-1:0] RST_REFR       = 32'd4200;
	localparam logic [CFG_CNT_W-1:0] RST_MIN_MOTION = 32'd300;
	localparam logic [CFG_CNT_W-1:0] RST_MIN_STEADY = 32'd150000;

	typedef struct packed {
		logic [RIP_W-1:0]     rip_thr;
		logic [MOT_W-1:0]     mot_thr;
		logic [WLEN_W-1:0]    wlen;
		logic [CFG_CNT_W-1:0] min_above;
		logic [CFG_CNT_W-1:0] refr;
		logic [MODE_W-1:0]    mode;
		logic [CFG_CNT_W-1:0] min_motion;
		logic [CFG_CNT_W-1:0] min_steady;
	} cfg_t;

	// closed window handed from front to back
	typedef struct packed {
		logic [RIP_W-1:0] rsum;
		logic [MOT_W-1:0] msum;
	} win_rec_t;

endpackage

// ===== rtl/rrd_in_if.sv =====
// sample channel interface
interface rrd_in_if import rrd_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] ripple_sample;
	logic signed [SAMPLE_BITS-1:0] emg_sample;
	logic signed [SAMPLE_BITS-1:0] accel_x;
	logic signed [SAMPLE_BITS-1:0] accel_y;
	logic signed [SAMPLE_BITS-1:0] accel_z;

	modport source (output valid, ripple_sample, emg_sample, accel_x, accel_y, accel_z,
		input ready);
	modport sink (input valid, ripple_sample, emg_sample, accel_x, accel_y, accel_z,
		output ready);
endinterface

// ===== rtl/rrd_out_if.sv =====
// window result channel interface
interface rrd_out_if import rrd_pkg::*;;
	logic             valid;
	logic             ready;
	logic             ripple_rise;
	logic             ripple_fall;
	logic             ripple_blocked;
	logic             motion_rise;
	logic             motion_fall;
	logic             detection_on;
	logic [RIP_W-1:0] window_sumsq;

	modport source (output valid, ripple_rise, ripple_fall, ripple_blocked, motion_rise,
		motion_fall, detection_on, window_sumsq, input ready);
	modport sink (input valid, ripple_rise, ripple_fall, ripple_blocked, motion_rise,
		motion_fall, detection_on, window_sumsq, output ready);
endinterface

// ===== rtl/rrd_front.sv =====
// front end: squares samples and accumulates window sums
module rrd_front import rrd_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
	localparam int WP_W       = $clog2(MAX_WINDOW + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	rrd_in_if.sink          smp,
	input  cfg_t            cfg,
	input  logic [WP_W-1:0] win_len,
	input  logic            q_full,
	output logic            q_push,
	output win_rec_t        q_data
);

	localparam int SQ_W = 2 * SAMPLE_BITS;
	localparam int MS_W = SQ_W + 2;
	localparam int RW   = ((RIP_W > SQ_W) ? RIP_W : SQ_W) + 1;
	localparam int MW   = ((MOT_W > MS_W) ? MOT_W : MS_W) + 1;
	localparam logic [RW-1:0] RIP_CAP = {{(RW - RIP_W){1'b0}}, {RIP_W{1'b1}}};
	localparam logic [MW-1:0] MOT_CAP = {{(MW - MOT_W){1'b0}}, {MOT_W{1'b1}}};

	function automatic logic [SAMPLE_BITS-1:0] mag(input logic [SAMPLE_BITS-1:0] v);
		return v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
	endfunction

	logic [SAMPLE_BITS-1:0] r_mag, e_mag, x_mag, y_mag, z_mag;
	logic                   valid_s1, valid_s2;
	logic [SQ_W-1:0]        rsq_s1, esq_s1, xsq_s1, ysq_s1, zsq_s1;
	logic [SQ_W-1:0]        rsq_s2;
	logic [MS_W-1:0]        msq_s1_sel;
	logic [MS_W-1:0]        msq_s2;
	logic [RIP_W-1:0]       rip_acc_q, rip_next;
	logic [MOT_W-1:0]       mot_acc_q, mot_next;
	logic [RW-1:0]          rip_sum;
	logic [MW-1:0]          mot_sum;
	logic [WP_W-1:0]        pos_q, pos_inc;
	logic                   close, stall, en;

	assign r_mag = mag(smp.ripple_sample);
	assign e_mag = mag(smp.emg_sample);
	assign x_mag = mag(smp.accel_x);
	assign y_mag = mag(smp.accel_y);
	assign z_mag = mag(smp.accel_z);

	always_comb begin
		unique case (cfg.mode)
			MODE_EMG:   msq_s1_sel = MS_W'(esq_s1);
			MODE_ACCEL: msq_s1_sel = MS_W'(xsq_s1) + MS_W'(ysq_s1) + MS_W'(zsq_s1);
			default:    msq_s1_sel = '0;
		endcase
	end

	assign rip_sum  = RW'(rip_acc_q) + RW'(rsq_s2);
	assign mot_sum  = MW'(mot_acc_q) + MW'(msq_s2);
	assign rip_next = (rip_sum > RIP_CAP) ? {RIP_W{1'b1}} : rip_sum[RIP_W-1:0];
	assign mot_next = (mot_sum > MOT_CAP) ? {MOT_W{1'b1}} : mot_sum[MOT_W-1:0];

	assign pos_inc = pos_q + 1'b1;
	assign close   = pos_inc >= win_len;
	// hold the whole front while a closing window cannot enter the queue
	assign stall   = valid_s2 && close && q_full;
	assign en      = !stall;

	assign smp.ready   = en;
	assign q_push      = valid_s2 && close && !q_full;
	assign q_data.rsum = rip_next;
	assign q_data.msum = mot_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			rip_acc_q <= '0;
			mot_acc_q <= '0;
			pos_q     <= '0;
		end else if (en) begin
			valid_s1 <= smp.valid;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				if (close) begin
					rip_acc_q <= '0;
					mot_acc_q <= '0;
					pos_q     <= '0;
				end else begin
					rip_acc_q <= rip_next;
					mot_acc_q <= mot_next;
					pos_q     <= pos_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsq_s1 <= SQ_W'(r_mag) * SQ_W'(r_mag);
			esq_s1 <= SQ_W'(e_mag) * SQ_W'(e_mag);
			xsq_s1 <= SQ_W'(x_mag) * SQ_W'(x_mag);
			ysq_s1 <= SQ_W'(y_mag) * SQ_W'(y_mag);
			zsq_s1 <= SQ_W'(z_mag) * SQ_W'(z_mag);
			rsq_s2 <= rsq_s1;
			msq_s2 <= msq_s1_sel;
		end
	end

endmodule

// ===== rtl/rrd_queue.sv =====
// short queue of closed windows between front and back
module rrd_queue import rrd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  win_rec_t push_data,
	output logic     full,
	input  logic     pop,
	output win_rec_t pop_data,
	output logic     valid
);

	localparam int PW   = $clog2(QUEUE_DEPTH);
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNTW-1:0] FULL_CNT = CNTW'(QUEUE_DEPTH);

	win_rec_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] cnt_q;

	assign full     = cnt_q == FULL_CNT;
	assign valid    = cnt_q != '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== rtl/rrd_back.sv =====
// back end: window decisions, refractory, motion gate and result register
module rrd_back import rrd_pkg::*; #(
	parameter int COUNT_BITS = DEF_COUNT_BITS,
	parameter int MAX_WINDOW = DEF_MAX_WINDOW,
	localparam int WP_W      = $clog2(MAX_WINDOW + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic [WP_W-1:0] win_len,
	input  logic            q_valid,
	input  win_rec_t        q_data,
	output logic            q_pop,
	rrd_out_if.source       res
);

	localparam int CB = COUNT_BITS;
	localparam int SW = ((CB > WP_W) ? CB : WP_W) + 1;
	localparam int CW = (CB > CFG_CNT_W) ? CB : CFG_CNT_W;

	function automatic logic [CB-1:0] cnt_add(input logic [CB-1:0] a,
		input logic [WP_W-1:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(b);
		return (s > SW'({CB{1'b1}})) ? {CB{1'b1}} : s[CB-1:0];
	endfunction

	function automatic logic cnt_gt(input logic [CB-1:0] a, input logic [CFG_CNT_W-1:0] b);
		return CW'(a) > CW'(b);
	endfunction

	function automatic logic cnt_ge(input logic [CB-1:0] a, input logic [CFG_CNT_W-1:0] b);
		return CW'(a) >= CW'(b);
	endfunction

	logic [CB-1:0] above_q, elapsed_q, up_q, down_q;
	logic          dur_met_q, pulse_q, in_ref_q, up_met_q, down_met_q, enabled_q;
	logic [CB-1:0] above_nx, elapsed_nx, up_nx, down_nx;
	logic          dur_nx, in_ref_nx, up_met_nx, down_met_nx, en_nx;
	logic [CB-1:0] elapsed_sum, above_sum, up_sum, down_sum;
	logic          gate, en_a, m_fall_a, above_gt, mot_gt, fire, up_hit, down_hit, e_b;
	logic          r_rise, r_fall, r_blk, m_rise, m_fall;
	logic          out_valid_q;

	assign q_pop = q_valid && (!out_valid_q || res.ready);

	assign elapsed_sum = cnt_add(elapsed_q, win_len);
	assign above_sum   = cnt_add(above_q, win_len);
	assign up_sum      = cnt_add(up_q, win_len);
	assign down_sum    = cnt_add(down_q, win_len);

	always_comb begin
		gate     = (cfg.mode == MODE_EMG) || (cfg.mode == MODE_ACCEL);
		// with the gate off a disabled detector comes back at the window close
		en_a     = enabled_q | ~gate;
		m_fall_a = ~gate & ~enabled_q;

		r_fall   = pulse_q & en_a;
		above_gt = q_data.rsum > cfg.rip_thr;
		above_nx = above_gt ? above_sum : '0;
		dur_nx   = above_gt & (dur_met_q | cnt_gt(above_sum, cfg.min_above));
		fire     = dur_nx & ~in_ref_q;
		r_rise   = fire & en_a;
		r_blk    = fire & ~en_a;

		elapsed_nx = fire ? '0 : (in_ref_q ? elapsed_sum : elapsed_q);
		in_ref_nx  = fire ? (cfg.refr != '0) : (in_ref_q & ~cnt_ge(elapsed_sum, cfg.refr));

		mot_gt   = q_data.msum > cfg.mot_thr;
		up_hit   = mot_gt & cnt_gt(up_sum, cfg.min_motion);
		down_hit = mot_gt ? (~up_hit & cnt_gt(down_q, cfg.min_steady))
			: cnt_gt(down_sum, cfg.min_steady);

		if (gate) begin
			up_nx       = mot_gt ? up_sum : '0;
			up_met_nx   = up_hit | (mot_gt & up_met_q);
			down_nx     = up_hit ? '0 : (mot_gt ? down_q : down_sum);
			down_met_nx = down_hit | (~mot_gt & down_met_q);
			m_rise      = en_a & up_met_nx;
			e_b         = en_a & ~up_met_nx;
			m_fall      = ~e_b & down_met_nx;
			en_nx       = e_b | down_met_nx;
		end else begin
			up_nx       = up_q;
			up_met_nx   = up_met_q;
			down_nx     = down_q;
			down_met_nx = down_met_q;
			m_rise      = 1'b0;
			e_b         = en_a;
			m_fall      = m_fall_a;
			en_nx       = en_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q     <= '0;
			elapsed_q   <= '0;
			up_q        <= '0;
			down_q      <= '0;
			dur_met_q   <= 1'b0;
			pulse_q     <= 1'b0;
			in_ref_q    <= 1'b0;
			up_met_q    <= 1'b0;
			down_met_q  <= 1'b0;
			enabled_q   <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				above_q    <= above_nx;
				elapsed_q  <= elapsed_nx;
				up_q       <= up_nx;
				down_q     <= down_nx;
				dur_met_q  <= dur_nx;
				pulse_q    <= fire;
				in_ref_q   <= in_ref_nx;
				up_met_q   <= up_met_nx;
				down_met_q <= down_met_nx;
				enabled_q  <= en_nx;
			end
			if (q_pop) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res.ripple_rise    <= r_rise;
			res.ripple_fall    <= r_fall;
			res.ripple_blocked <= r_blk;
			res.motion_rise    <= m_rise;
			res.motion_fall    <= m_fall;
			res.detection_on   <= en_nx;
			res.window_sumsq   <= q_data.rsum;
		end
	end

	assign res.valid = out_valid_q;

endmodule

// ===== rtl/rms_ripple_detector_with_motion_gate_top.sv =====
// top level of the windowed sum-of-squares ripple detector with motion gate
//
// sample_ch takes one transaction per sample: a ripple sample plus the emg and
// accelerometer samples, only the ones the motion mode selects are used.
// result_ch gives one transaction for each closed window of window_length samples,
// carrying the ripple/motion events, the enable level and the window sum.
// configuration is written through cfg_wen/cfg_idx/cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this. throughput: one
// sample per cycle unless the front stalls on a full window queue; the front squares at
// the accepting edge, then registers the squares and the motion sum, then accumulates
// and pushes each closed window into the window queue, and the back loads the result
// register from the queue whenever that register is free or being taken. a two-entry
// window queue lets the front keep running while the back waits; when the result
// register is held by a stalled receiver and the queue fills, sample_ch ready drops at
// the next closing sample. reset clears the sums, counters and flags, enables detection
// and loads the register defaults; no transaction is in flight after reset.
module rms_ripple_detector_with_motion_gate_top import rrd_pkg::*; #(
	parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rrd_in_if.sink                sample_ch,
	rrd_out_if.source             result_ch,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int WP_W = $clog2(MAX_WINDOW + 1);
	localparam int LW   = ((WP_W > WLEN_W) ? WP_W : WLEN_W) + 1;
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_WINDOW);

	cfg_t            cfg_q;
	logic [LW-1:0]   wlen_ext;
	logic [WP_W-1:0] win_len;
	logic            q_push, q_full, q_pop, q_valid;
	win_rec_t        q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rip_thr    <= '0;
			cfg_q.mot_thr    <= '0;
			cfg_q.wlen       <= RST_WLEN;
			cfg_q.min_above  <= RST_MIN_ABOVE;
			cfg_q.refr       <= RST_REFR;
			cfg_q.mode       <= MODE_OFF;
			cfg_q.min_motion <= RST_MIN_MOTION;
			cfg_q.min_steady <= RST_MIN_STEADY;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				CFG_RIP_THR:    cfg_q.rip_thr    <= cfg_wdata[RIP_W-1:0];
				CFG_MOT_THR:    cfg_q.mot_thr    <= cfg_wdata[MOT_W-1:0];
				CFG_WLEN:       cfg_q.wlen       <= cfg_wdata[WLEN_W-1:0];
				CFG_MIN_ABOVE:  cfg_q.min_above  <= cfg_wdata[CFG_CNT_W-1:0];
				CFG_REFR:       cfg_q.refr       <= cfg_wdata[CFG_CNT_W-1:0];
				CFG_MODE:       cfg_q.mode       <= cfg_wdata[MODE_W-1:0];
				CFG_MIN_MOTION: cfg_q.min_motion <= cfg_wdata[CFG_CNT_W-1:0];
				CFG_MIN_STEADY: cfg_q.min_steady <= cfg_wdata[CFG_CNT_W-1:0];
			endcase
		end
	end

	// zero length acts as one, long windows clamp to the maximum
	assign wlen_ext = LW'(cfg_q.wlen);
	always_comb begin
		priority if (wlen_ext == '0) win_len = WP_W'(1);
		else if (wlen_ext > MAX_LEN) win_len = MAX_LEN[WP_W-1:0];
		else win_len = wlen_ext[WP_W-1:0];
	end

	rrd_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_WINDOW  (MAX_WINDOW)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.smp     (sample_ch),
		.cfg     (cfg_q),
		.win_len (win_len),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_wdata)
	);

	rrd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.valid     (q_valid)
	);

	rrd_back #(
		.COUNT_BITS (COUNT_BITS),
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.win_len (win_len),
		.q_valid (q_valid),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.res     (result_ch)
	);

endmodule

// ===== rtl/rrd_checker.sv =====
// port-level checks on the result channel, bound to the top level
module rrd_checker import rrd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             res_valid,
	input logic             res_ready,
	input logic             res_ripple_rise,
	input logic             res_ripple_blocked,
	input logic             res_motion_fall,
	input logic             res_detection_on,
	input logic [RIP_W-1:0] res_window_sumsq
);

	// a stalled transaction keeps its window sum
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_window_sumsq))
		else $error("result changed while stalled");

	// a detection is either passed or blocked, never both
	a_rise_blk: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_ripple_rise && res_ripple_blocked))
		else $error("ripple both raised and blocked");

	// a re-enable always leaves detection on
	a_mfall_on: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_motion_fall |-> res_detection_on)
		else $error("motion fall with detection off");

	a_rst: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

endmodule

bind rms_ripple_detector_with_motion_gate_top rrd_checker u_rrd_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.res_valid          (result_ch.valid),
	.res_ready          (result_ch.ready),
	.res_ripple_rise    (result_ch.ripple_rise),
	.res_ripple_blocked (result_ch.ripple_blocked),
	.res_motion_fall    (result_ch.motion_fall),
	.res_detection_on   (result_ch.detection_on),
	.res_window_sumsq   (result_ch.window_sumsq)
);

// ===== tb/rms_ripple_detector_with_motion_gate_top_test.sv =====
// self-checking testbench: ripple detector windows predicted per sample and compared per field
module rms_ripple_detector_with_motion_gate_top_test;
	import rrd_pkg::*;

	localparam int MAX_WIN        = DEF_MAX_WINDOW;
	localparam int PIPE_SETTLE    = 8;
	localparam int STALL_CYCLES   = 300;
	localparam int WATCHDOG_LIMIT = 4000;

	localparam longint unsigned RIP_CAP = (64'd1 << RIP_W) - 1;
	localparam longint unsigned MOT_CAP = (64'd1 << MOT_W) - 1;
	localparam longint unsigned CNT_CAP = (64'd1 << DEF_COUNT_BITS) - 1;

	// motion source code that the block treats as gate off
	localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;

	typedef struct {
		logic signed [DEF_SAMPLE_BITS-1:0] ripple;
		logic signed [DEF_SAMPLE_BITS-1:0] emg;
		logic signed [DEF_SAMPLE_BITS-1:0] ax;
		logic signed [DEF_SAMPLE_BITS-1:0] ay;
		logic signed [DEF_SAMPLE_BITS-1:0] az;
	} sample_t;

	typedef struct {
		logic             ripple_rise;
		logic             ripple_fall;
		logic             ripple_blocked;
		logic             motion_rise;
		logic             motion_fall;
		logic             detection_on;
		logic [RIP_W-1:0] window_sumsq;
	} window_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	rrd_in_if  sample_ch();
	rrd_out_if result_ch();

	rms_ripple_detector_with_motion_gate_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// detector copy: register file and per-window state
	cfg_t            cfg;
	longint unsigned rip_acc, mot_acc, win_pos, above_cnt, refr_elapsed;
	longint unsigned mot_up_cnt, mot_dn_cnt;
	bit              dur_met, pulse_on, refr_on, mot_up_met, mot_dn_met, det_on;

	sample_t        sample_q[$];
	window_result_t window_results_q[$];

	int  tx_idle_pct, rx_idle_pct;
	bit  stall_req;
	int  stall_cycles_done;
	bit  sample_taken, result_taken;
	int  idle_cycles;
	int  mismatches, samples_seen, windows_seen, cfg_writes;
	int  pulses_predicted, blocked_predicted, gate_changes;

	function automatic longint unsigned square(input logic signed [DEF_SAMPLE_BITS-1:0] v);
		longint sv;
		sv = v;
		return longint'(sv * sv);
	endfunction

	function automatic longint unsigned sat_add(input longint unsigned a, input longint unsigned b,
		input longint unsigned cap);
		if (a >= cap || b > cap - a)
			return cap;
		return a + b;
	endfunction

	// folds one sample into the window sums; returns 1 when it closes a window
	function automatic bit predict_window(input sample_t s, output window_result_t w);
		longint unsigned n, msq, rsum;
		bit gate;
		w = '{default: '0};
		n = (cfg.wlen == 0) ? 1 : ((cfg.wlen > MAX_WIN) ? MAX_WIN : cfg.wlen);
		gate = (cfg.mode == MODE_EMG) || (cfg.mode == MODE_ACCEL);
		rip_acc = sat_add(rip_acc, square(s.ripple), RIP_CAP);
		msq = 0;
		if (cfg.mode == MODE_EMG)
			msq = square(s.emg);
		else if (cfg.mode == MODE_ACCEL)
			msq = square(s.ax) + square(s.ay) + square(s.az);
		mot_acc = sat_add(mot_acc, msq, MOT_CAP);
		win_pos++;
		// a shortened length closes the window as soon as the count reaches it
		if (win_pos < n)
			return 1'b0;
		rsum = rip_acc;
		win_pos = 0;
		if (!gate && !det_on) begin
			det_on = 1'b1;
			w.motion_fall = 1'b1;
		end
		if (refr_on)
			refr_elapsed = sat_add(refr_elapsed, n, CNT_CAP);
		if (pulse_on) begin
			if (det_on)
				w.ripple_fall = 1'b1;
			pulse_on = 1'b0;
		end
		if (rsum > cfg.rip_thr) begin
			above_cnt = sat_add(above_cnt, n, CNT_CAP);
		end else begin
			above_cnt = 0;
			dur_met = 1'b0;
		end
		if (above_cnt > cfg.min_above)
			dur_met = 1'b1;
		if (dur_met && !refr_on) begin
			if (det_on)
				w.ripple_rise = 1'b1;
			else
				w.ripple_blocked = 1'b1;
			pulse_on = 1'b1;
			refr_on = 1'b1;
			refr_elapsed = 0;
		end
		// zero refractory ends in the window that fired
		if (refr_on && refr_elapsed >= cfg.refr)
			refr_on = 1'b0;
		if (gate) begin
			if (mot_acc > cfg.mot_thr) begin
				mot_up_cnt = sat_add(mot_up_cnt, n, CNT_CAP);
				mot_dn_met = 1'b0;
			end else begin
				mot_dn_cnt = sat_add(mot_dn_cnt, n, CNT_CAP);
				mot_up_met = 1'b0;
				mot_up_cnt = 0;
			end
			if (mot_up_cnt > cfg.min_motion) begin
				mot_up_met = 1'b1;
				mot_dn_cnt = 0;
			end
			if (mot_dn_cnt > cfg.min_steady)
				mot_dn_met = 1'b1;
			if (det_on && mot_up_met) begin
				det_on = 1'b0;
				w.motion_rise = 1'b1;
			end
			if (!det_on && mot_dn_met) begin
				det_on = 1'b1;
				w.motion_fall = 1'b1;
			end
		end
		rip_acc = 0;
		mot_acc = 0;
		w.detection_on = det_on;
		w.window_sumsq = rsum[RIP_W-1:0];
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("window %0d %s got %0h want %0h", windows_seen, name, got,
				want));
	endtask

	// sample side: a new transaction goes out once the previous one was taken
	always @(negedge clk) begin
		sample_t nxt;
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else if (!sample_ch.valid || sample_taken) begin
			if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				nxt = sample_q.pop_front();
				sample_ch.ripple_sample <= nxt.ripple;
				sample_ch.emg_sample    <= nxt.emg;
				sample_ch.accel_x       <= nxt.ax;
				sample_ch.accel_y       <= nxt.ay;
				sample_ch.accel_z       <= nxt.az;
				sample_ch.valid         <= 1'b1;
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (stall_req && stall_cycles_done < STALL_CYCLES) begin
			// long hold-off so closed windows back up into the sample side
			result_ch.ready <= 1'b0;
			stall_cycles_done++;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		window_result_t want;
		sample_t s;
		sample_taken = sample_ch.valid && sample_ch.ready;
		result_taken = result_ch.valid && result_ch.ready;
		if (result_taken) begin
			windows_seen++;
			if (window_results_q.size() == 0) begin
				report_mismatch($sformatf("window result %0d with no window closed", windows_seen));
			end else begin
				want = window_results_q.pop_front();
				check_field("ripple_rise", result_ch.ripple_rise, want.ripple_rise);
				check_field("ripple_fall", result_ch.ripple_fall, want.ripple_fall);
				check_field("ripple_blocked", result_ch.ripple_blocked, want.ripple_blocked);
				check_field("motion_rise", result_ch.motion_rise, want.motion_rise);
				check_field("motion_fall", result_ch.motion_fall, want.motion_fall);
				check_field("detection_on", result_ch.detection_on, want.detection_on);
				check_field("window_sumsq", result_ch.window_sumsq, want.window_sumsq);
			end
		end
		if (sample_taken) begin
			samples_seen++;
			s.ripple = sample_ch.ripple_sample;
			s.emg    = sample_ch.emg_sample;
			s.ax     = sample_ch.accel_x;
			s.ay     = sample_ch.accel_y;
			s.az     = sample_ch.accel_z;
			if (predict_window(s, want)) begin
				window_results_q.insert(window_results_q.size(), want);
				pulses_predicted  += want.ripple_rise;
				blocked_predicted += want.ripple_blocked;
				gate_changes      += want.motion_rise + want.motion_fall;
			end
		end
		if (sample_taken || result_taken || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: %0d cycles without a transaction", WATCHDOG_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input longint unsigned data);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= CFG_DATA_W'(data);
		@(posedge clk);
		cfg_writes++;
		case (idx)
			CFG_RIP_THR:    cfg.rip_thr    = data[RIP_W-1:0];
			CFG_MOT_THR:    cfg.mot_thr    = data[MOT_W-1:0];
			CFG_WLEN:       cfg.wlen       = data[WLEN_W-1:0];
			CFG_MIN_ABOVE:  cfg.min_above  = data[CFG_CNT_W-1:0];
			CFG_REFR:       cfg.refr       = data[CFG_CNT_W-1:0];
			CFG_MODE:       cfg.mode       = data[MODE_W-1:0];
			CFG_MIN_MOTION: cfg.min_motion = data[CFG_CNT_W-1:0];
			default:        cfg.min_steady = data[CFG_CNT_W-1:0];
		endcase
	endtask

	task automatic cfg_done();
		@(negedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	// nothing queued, nothing in flight, then let samples that close no window settle
	task automatic wait_drained();
		while (sample_q.size() != 0 || sample_ch.valid || window_results_q.size() != 0)
			@(negedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic push_sample(input int r, input int e, input int x, input int y, input int z);
		sample_t s;
		s.ripple = 16'(r);
		s.emg    = 16'(e);
		s.ax     = 16'(x);
		s.ay     = 16'(y);
		s.az     = 16'(z);
		sample_q.insert(sample_q.size(), s);
	endtask

	// loud, quiet or raw noise, picked per burst
	function automatic logic signed [DEF_SAMPLE_BITS-1:0] level_sample(input int kind);
		int v;
		if (kind < 15)
			return 16'($urandom);
		if (kind < 55)
			v = $urandom_range(32767, 8000);
		else
			v = $urandom_range(150, 0);
		if ($urandom_range(1) != 0)
			v = -v;
		return 16'(v);
	endfunction

	task automatic push_bursts(input int count, input int n);
		int left, seg, kr, km, i;
		sample_t s;
		left = count;
		while (left > 0) begin
			seg = $urandom_range(3 * n, 1);
			kr = $urandom_range(99);
			km = $urandom_range(99);
			for (i = 0; i < seg && left > 0; i++) begin
				s.ripple = level_sample(kr);
				s.emg    = level_sample(km);
				s.ax     = level_sample(km);
				s.ay     = level_sample(km);
				s.az     = level_sample(km);
				sample_q.insert(sample_q.size(), s);
				left--;
			end
		end
	endtask

	function automatic longint unsigned extreme_or(input longint unsigned top,
		input longint unsigned typical);
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 0;
		if (r == 1)
			return top;
		return typical;
	endfunction

	initial begin
		int ph, n, wl, r;
		logic [MODE_W-1:0] mode;

		arst_n                  = 1'b1;
		cfg_wen                 = 1'b0;
		cfg_idx                 = '0;
		cfg_wdata               = '0;
		sample_ch.valid         = 1'b0;
		sample_ch.ripple_sample = '0;
		sample_ch.emg_sample    = '0;
		sample_ch.accel_x       = '0;
		sample_ch.accel_y       = '0;
		sample_ch.accel_z       = '0;
		result_ch.ready         = 1'b0;

		cfg.rip_thr    = '0;
		cfg.mot_thr    = '0;
		cfg.wlen       = RST_WLEN;
		cfg.min_above  = RST_MIN_ABOVE;
		cfg.refr       = RST_REFR;
		cfg.mode       = MODE_OFF;
		cfg.min_motion = RST_MIN_MOTION;
		cfg.min_steady = RST_MIN_STEADY;
		rip_acc = 0; mot_acc = 0; win_pos = 0; above_cnt = 0; refr_elapsed = 0;
		mot_up_cnt = 0; mot_dn_cnt = 0;
		dur_met = 0; pulse_on = 0; refr_on = 0; mot_up_met = 0; mot_dn_met = 0;
		det_on = 1'b1;

		tx_idle_pct = 12;
		rx_idle_pct = 48;
		// a clean falling edge on the reset before the first clock
		#1 arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: 128-sample windows, gate off, zero threshold
		push_bursts(256, 128);
		wait_drained();

		// one-sample windows with every limit at zero, so each window with a nonzero ripple sample fires
		cfg_write(CFG_RIP_THR, 0);
		cfg_write(CFG_MOT_THR, 0);
		cfg_write(CFG_WLEN, 0);
		cfg_write(CFG_MIN_ABOVE, 0);
		cfg_write(CFG_REFR, 0);
		cfg_write(CFG_MODE, 64'(MODE_EMG));
		cfg_write(CFG_MIN_MOTION, 0);
		cfg_write(CFG_MIN_STEADY, 0);
		cfg_done();
		push_sample(32767, 32767, 0, 0, 0);
		push_sample(-32768, -32768, 0, 0, 0);
		push_sample(0, 0, 0, 0, 0);
		push_sample(-1, -1, 0, 0, 0);
		push_sample(1, 0, 0, 0, 0);
		push_sample(21845, -21846, 0, 0, 0);
		push_sample(-21846, 21845, 0, 0, 0);
		wait_drained();

		cfg_write(CFG_MODE, 64'(MODE_ACCEL));
		cfg_done();
		push_sample(100, 0, -32768, -32768, -32768);
		push_sample(0, 0, 0, 0, 0);
		push_sample(32767, -1, 32767, 32767, 32767);
		push_sample(-1, 0, 21845, -21846, -1);
		wait_drained();

		cfg_write(CFG_MODE, 64'(MODE_RSVD));
		cfg_done();
		push_sample(-32768, 32767, 32767, 32767, 32767);
		push_sample(0, -32768, -32768, -1, 1);
		wait_drained();

		// disable on motion, then turn the gate off: the next window re-enables
		cfg_write(CFG_MODE, 64'(MODE_EMG));
		cfg_done();
		push_sample(5, 30000, 0, 0, 0);
		wait_drained();
		cfg_write(CFG_MODE, 64'(MODE_OFF));
		cfg_done();
		push_sample(5, 0, 0, 0, 0);
		wait_drained();

		// every limit at its top; spare upper data bits must be dropped
		cfg_write(CFG_RIP_THR, RIP_CAP);
		cfg_write(CFG_MOT_THR, MOT_CAP);
		cfg_write(CFG_MIN_ABOVE, CNT_CAP);
		cfg_write(CFG_REFR, CNT_CAP);
		cfg_write(CFG_MIN_MOTION, CNT_CAP);
		cfg_write(CFG_MIN_STEADY, CNT_CAP);
		cfg_write(CFG_MODE, 64'({41'h155_5555_5555, MODE_ACCEL}));
		cfg_write(CFG_WLEN, 64'({31'h5555_5555, 12'd2}));
		cfg_done();
		push_bursts(4, 2);
		wait_drained();

		// window cut short after it has started
		cfg_write(CFG_WLEN, 16);
		cfg_done();
		push_bursts(5, 16);
		wait_drained();
		cfg_write(CFG_WLEN, 3);
		cfg_done();
		push_bursts(1, 3);
		wait_drained();

		// longest length is clamped to the maximum window, then a short one closes it
		cfg_write(CFG_WLEN, 64'hfff);
		cfg_write(CFG_RIP_THR, 0);
		cfg_write(CFG_MIN_ABOVE, 0);
		cfg_done();
		push_bursts(150, 64);
		wait_drained();
		cfg_write(CFG_WLEN, 4);
		cfg_done();
		push_bursts(1, 4);
		wait_drained();

		for (ph = 0; ph < 9; ph++) begin
			tx_idle_pct = (ph < 3) ? 12 : ((ph < 6) ? 48 : 0);
			rx_idle_pct = (ph < 3) ? 48 : ((ph < 6) ? 12 : 0);
			r = $urandom_range(99);
			if (r < 70)
				wl = $urandom_range(8, 1);
			else if (r < 80)
				wl = 0;
			else
				wl = $urandom_range(40, 9);
			if (ph == 1)
				wl = 2;
			n = (wl == 0) ? 1 : wl;
			r = $urandom_range(9);
			mode = (r < 4) ? MODE_EMG : ((r < 8) ? MODE_ACCEL : ((r < 9) ? MODE_OFF : MODE_RSVD));
			cfg_write(CFG_WLEN, 64'(wl));
			cfg_write(CFG_MODE, 64'(mode));
			cfg_write(CFG_RIP_THR,
				extreme_or(RIP_CAP, 64'(longint'(n) * $urandom_range(20_000_000, 200_000))));
			cfg_write(CFG_MOT_THR,
				extreme_or(MOT_CAP, 64'(longint'(n) * $urandom_range(40_000_000, 200_000))));
			cfg_write(CFG_MIN_ABOVE, extreme_or(CNT_CAP, 64'($urandom_range(4 * n, 0))));
			cfg_write(CFG_REFR, extreme_or(CNT_CAP, 64'($urandom_range(8 * n, 0))));
			cfg_write(CFG_MIN_MOTION, extreme_or(CNT_CAP, 64'($urandom_range(3 * n, 0))));
			cfg_write(CFG_MIN_STEADY, extreme_or(CNT_CAP, 64'($urandom_range(6 * n, 0))));
			cfg_done();
			if (ph == 1)
				stall_req = 1'b1;
			if (ph == 4) begin
				// sender holds back until every window result is in
				push_bursts(20, n);
				wait_drained();
				push_bursts(20, n);
			end else begin
				push_bursts(40, n);
			end
			wait_drained();
		end

		$display("covered %0d samples, %0d window results and %0d register writes",
			samples_seen, windows_seen, cfg_writes);
		$display("%0d ripple pulses, %0d motion-blocked ripples, %0d gate changes, %0d mismatches",
			pulses_predicted, blocked_predicted, gate_changes, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
